/* rtl/core/sha512_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 package
// Round constants, initial values, shared types and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha512_pkg;

    localparam int WordW   = 64;
    localparam int Rounds  = 80;
    localparam int BlkWords = 16;
    localparam logic [7:0] PadByte = 8'h80;
    localparam int LengthLimitWords = 112 / 8;

    typedef logic [WordW-1:0] word_t;

    // queue entry between front and back: one word for the block buffer
    typedef struct packed {
        word_t word;
        logic  last_of_msg;   // final length word of a message: emit digest after it
    } fe_entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_ADD,
        BK_OUT
    } bk_state_t;

    typedef enum logic [1:0] {
        FE_TAKE,
        FE_PAD,
        FE_LEN
    } fe_state_t;

    localparam logic [0:0] RegDigestMode = 1'b0;
    localparam logic [1:0] AddrDigestMode = 2'({RegDigestMode, 2'b00});

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic word_t round_k(input logic [6:0] i);
        word_t r;
        r = '0;
        case (i)
            7'd0: r = 64'h428a2f98d728ae22;  7'd1: r = 64'h7137449123ef65cd;
            7'd2: r = 64'hb5c0fbcfec4d3b2f;  7'd3: r = 64'he9b5dba58189dbbc;
            7'd4: r = 64'h3956c25bf348b538;  7'd5: r = 64'h59f111f1b605d019;
            7'd6: r = 64'h923f82a4af194f9b;  7'd7: r = 64'hab1c5ed5da6d8118;
            7'd8: r = 64'hd807aa98a3030242;  7'd9: r = 64'h12835b0145706fbe;
            7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
            7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
            7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
            7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
            7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
            7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
            7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
            7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
            7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
            7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
            7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
            7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
            7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
            7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
            7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
            7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
            7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
            7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
            7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
            7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
            7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
            7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
            7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
            7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
            7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
            7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
            7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
            7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
            7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
            7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
            7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
            7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
            7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
            7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
            7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
            default: r = '0;
        endcase
        round_k = r;
    endfunction

    function automatic word_t init_value(input logic mode, input logic [2:0] i);
        word_t r;
        r = '0;
        if (!mode) begin
            case (i)
                3'd0: r = 64'h6a09e667f3bcc908; 3'd1: r = 64'hbb67ae8584caa73b;
                3'd2: r = 64'h3c6ef372fe94f82b; 3'd3: r = 64'ha54ff53a5f1d36f1;
                3'd4: r = 64'h510e527fade682d1; 3'd5: r = 64'h9b05688c2b3e6c1f;
                3'd6: r = 64'h1f83d9abfb41bd6b; default: r = 64'h5be0cd19137e2179;
            endcase
        end else begin
            case (i)
                3'd0: r = 64'hcbbb9d5dc1059ed8; 3'd1: r = 64'h629a292a367cd507;
                3'd2: r = 64'h9159015a3070dd17; 3'd3: r = 64'h152fecd8f70e5939;
                3'd4: r = 64'h67332667ffc00b31; 3'd5: r = 64'h8eb44a8768581511;
                3'd6: r = 64'hdb0c2e0d64f98fa7; default: r = 64'h47b5481dbefa4fa4;
            endcase
        end
        init_value = r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/sha512_front.sv */
// ----------------------------------------------------------------------------
// SHA-512 front end
// Accepts message words, counts bits, applies padding and the length word,
// and pushes block words into the queue toward the compression engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_front
    import sha512_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      restart,
    input  wire logic      push,
    output logic           full,
    input  wire word_t     message_word,
    input  wire logic [3:0] valid_bytes,
    input  wire logic      final_word,
    output logic           q_push,
    output fe_entry_t      q_data,
    input  wire logic      q_full
);

    fe_state_t   state_reg, state_next;
    word_t       bits_reg, bits_next;
    logic [3:0]  slot_reg, slot_next;
    logic        pad_two_reg, pad_two_next;  // full final word: pad byte still owed
    logic        len_hi_reg, len_hi_next;    // set after the upper zero half: next length word is the bit count

    logic [3:0]  vb;
    word_t       keep;
    word_t       pad_word;
    logic        accept;

    always_comb
    begin
        vb = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
        keep = (vb == 4'd0) ? '0 : ~(word_t'('1) >> {vb[2:0], 3'b000});
        if (vb == 4'd8)
            keep = '1;
        pad_word = (message_word & keep) | (word_t'(PadByte) << (7'd56 - {vb[2:0], 3'b000}));
    end

    // hold off input during the restart cycle after a mode write
    assign full   = (state_reg != FE_TAKE) || q_full || restart;
    assign accept = push && !full;

    always_comb
    begin
        state_next   = state_reg;
        bits_next    = bits_reg;
        slot_next    = slot_reg;
        pad_two_next = pad_two_reg;
        len_hi_next  = len_hi_reg;
        q_push       = 1'b0;
        q_data       = '{word: '0, last_of_msg: 1'b0};
        unique case (state_reg)
            FE_TAKE:
            begin
                if (accept) begin
                    q_push    = 1'b1;
                    slot_next = slot_reg + 4'd1;
                    if (!final_word) begin
                        q_data.word = message_word;
                        bits_next   = bits_reg + 64'd64;
                    end else begin
                        bits_next = bits_reg + {57'd0, vb, 3'b000};
                        if (vb == 4'd8) begin
                            q_data.word  = message_word;
                            pad_two_next = 1'b1;
                        end else begin
                            q_data.word  = pad_word;
                            pad_two_next = 1'b0;
                        end
                        len_hi_next = 1'b0;
                        state_next  = FE_PAD;
                    end
                end
            end
            FE_PAD:
            begin
                // emit pad byte word, then zero fill up to the length field
                if (!q_full) begin
                    if (pad_two_reg) begin
                        q_push       = 1'b1;
                        q_data.word  = {PadByte, 56'd0};
                        pad_two_next = 1'b0;
                        slot_next    = slot_reg + 4'd1;
                    end else if (slot_reg != 4'(LengthLimitWords)) begin
                        q_push    = 1'b1;
                        slot_next = slot_reg + 4'd1;
                    end else begin
                        state_next = FE_LEN;
                    end
                end
            end
            FE_LEN:
            begin
                if (!q_full) begin
                    q_push    = 1'b1;
                    slot_next = slot_reg + 4'd1;
                    if (!len_hi_reg) begin
                        len_hi_next = 1'b1;
                    end else begin
                        q_data.word        = bits_reg;
                        q_data.last_of_msg = 1'b1;
                        bits_next          = '0;
                        state_next         = FE_TAKE;
                    end
                end
            end
            default: state_next = FE_TAKE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= FE_TAKE;
            bits_reg    <= '0;
            slot_reg    <= '0;
            pad_two_reg <= 1'b0;
            len_hi_reg  <= 1'b0;
        end else if (restart) begin
            state_reg   <= FE_TAKE;
            bits_reg    <= '0;
            slot_reg    <= '0;
            pad_two_reg <= 1'b0;
            len_hi_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bits_reg    <= bits_next;
            slot_reg    <= slot_next;
            pad_two_reg <= pad_two_next;
            len_hi_reg  <= len_hi_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sha512_queue.sv */
// ----------------------------------------------------------------------------
// SHA-512 word queue
// Short FIFO of block words between the front end and the compression engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_queue
    import sha512_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      flush,
    input  wire logic      wr,
    input  wire fe_entry_t wdata,
    output logic           q_full,
    input  wire logic      rd,
    output fe_entry_t      rdata,
    output logic           q_empty
);

    fe_entry_t  mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign q_full  = (cnt_reg == 3'd4);
    assign q_empty = (cnt_reg == 3'd0);
    assign rdata   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !q_full)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else if (flush) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr && !q_full)
                wp_reg <= wp_reg + 2'd1;
            if (rd && !q_empty)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr && !q_full) - 3'(rd && !q_empty);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sha512_back.sv */
// ----------------------------------------------------------------------------
// SHA-512 compression engine
// Loads block words, runs 80 rounds one per cycle with a rolling schedule,
// folds into the hash words and streams out the digest.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_back
    import sha512_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      restart,
    input  wire logic      mode,
    input  wire fe_entry_t q_data,
    input  wire logic      q_empty,
    output logic           q_pop,
    output word_t          digest_word,
    output logic [2:0]     digest_index,
    output logic           digest_last,
    output logic           empty,
    input  wire logic      pop
);

    bk_state_t  state_reg, state_next;
    word_t      h_reg [8];
    word_t      v_reg [8];
    word_t      w_reg [16];
    logic [3:0] slot_reg;
    logic [6:0] round_reg;
    logic       emit_reg;
    logic [2:0] out_idx_reg;

    word_t x15, x2, wnew, wj, t1, t2;
    logic  out_last;
    logic  take;

    always_comb
    begin
        x15  = w_reg[1];
        x2   = w_reg[14];
        wnew = w_reg[0] + (rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7)) + w_reg[9]
             + (rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6));
        wj   = (round_reg < 7'd16) ? w_reg[0] : wnew;
        t1 = v_reg[7] + (rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(round_reg) + wj;
        t2 = (rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign out_last = mode ? (out_idx_reg == 3'd5) : (out_idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (!q_empty && slot_reg == 4'd15) state_next = BK_ROUND;
            BK_ROUND: if (round_reg == 7'(Rounds - 1)) state_next = BK_ADD;
            BK_ADD:   state_next = emit_reg ? BK_OUT : BK_IDLE;
            BK_OUT:   if (pop && out_last) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        take         = (state_reg == BK_IDLE) && !q_empty;
        q_pop        = take;
        empty        = (state_reg != BK_OUT);
        digest_word  = h_reg[out_idx_reg];
        digest_index = out_idx_reg;
        digest_last  = out_last;
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            w_reg[slot_reg] <= q_data.word;
        end else if (state_reg == BK_ROUND) begin
            // rotate the schedule window: index 0 holds w[j] in the first 16 rounds, w[j-16] after
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wj;
        end
        if (take && slot_reg == 4'd15) begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end else if (state_reg == BK_ROUND) begin
            v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= BK_IDLE;
            slot_reg    <= '0;
            round_reg   <= '0;
            emit_reg    <= 1'b0;
            out_idx_reg <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_value(1'b0, 3'(i));
        end else if (restart) begin
            state_reg   <= BK_IDLE;
            slot_reg    <= '0;
            round_reg   <= '0;
            emit_reg    <= 1'b0;
            out_idx_reg <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_value(mode, 3'(i));
        end else begin
            state_reg <= state_next;
            if (take) begin
                slot_reg  <= slot_reg + 4'd1;
                round_reg <= '0;
                emit_reg  <= q_data.last_of_msg;
            end
            if (state_reg == BK_ROUND)
                round_reg <= round_reg + 7'd1;
            if (state_reg == BK_ADD) begin
                out_idx_reg <= '0;
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (state_reg == BK_OUT && pop) begin
                out_idx_reg <= out_idx_reg + 3'd1;
                // drop the finished digest, reload initial values
                if (out_last) begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= init_value(mode, 3'(i));
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sha512_stream_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 stream hasher
// Hashes a stream of 64-bit message words, pads the final block and returns
// the digest one word per transaction.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        message_word, valid_bytes, final_word
//  result    pop / empty        digest_word, digest_index, digest_last
//  config    APB psel/penable   paddr 0: digest_mode
//
//  A 16-word block takes 16 queue transfers, 80 rounds and a fold; the
//  single round unit sets the sustained rate. The final word adds padding
//  words at one per cycle while the queue is not full; the digest waits on
//  pop. Reset loads SHA-512 initial values; a write to digest_mode drops
//  any partial message. full holds while padding, while the queue is full
//  and in the cycle after a digest_mode write.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_stream_hasher
    import sha512_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] message_word,
    input  wire logic [3:0]  valid_bytes,
    input  wire logic        final_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      digest_word,
    output logic [2:0]       digest_index,
    output logic             digest_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic      mode_reg;
    logic      cfg_wr;
    logic      q_push, q_full, q_pop, q_empty;
    fe_entry_t q_wdata, q_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == AddrDigestMode);
    assign prdata = (paddr == AddrDigestMode) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_wr)
            mode_reg <= pwdata[0];
    end

    logic restart_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restart_reg <= 1'b0;
        else
            restart_reg <= cfg_wr;
    end

    sha512_front u_front (
        .clk, .rst_n, .restart(restart_reg), .push, .full,
        .message_word, .valid_bytes, .final_word,
        .q_push, .q_data(q_wdata), .q_full
    );

    sha512_queue u_queue (
        .clk, .rst_n, .flush(restart_reg), .wr(q_push), .wdata(q_wdata), .q_full,
        .rd(q_pop), .rdata(q_rdata), .q_empty
    );

    sha512_back u_back (
        .clk, .rst_n, .restart(restart_reg), .mode(mode_reg),
        .q_data(q_rdata), .q_empty, .q_pop,
        .digest_word, .digest_index, .digest_last, .empty, .pop
    );

endmodule

`default_nettype wire

/* rtl/core/sha512_checker.sv */
// ----------------------------------------------------------------------------
// SHA-512 port checker
// Watches the top-level ports for digest ordering and handshake sanity.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [2:0]  digest_index,
    input wire logic        digest_last,
    input wire logic [63:0] digest_word,
    input wire logic        pready
);

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digest_word)))
        else $error("result changed while waiting");

    a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !digest_last) |=>
            (!empty && digest_index == $past(digest_index) + 3'd1))
        else $error("digest index skipped");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && digest_last) |-> (digest_index == 3'd5 || digest_index == 3'd7))
        else $error("digest_last at wrong index");

endmodule

bind sha512_stream_hasher sha512_checker u_checker (
    .clk, .rst_n, .empty, .pop, .digest_index, .digest_last, .digest_word, .pready
);

`default_nettype wire
